// ===== rtl/i2cras_pkg.sv =====
package i2cras_pkg;

  // Item codes on the request channel.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;
  localparam logic [1:0] OP_ERROR  = 2'd3;

  // Completion codes on the response channel.
  localparam logic [1:0] DONE_NONE  = 2'd0;
  localparam logic [1:0] DONE_WRITE = 2'd1;
  localparam logic [1:0] DONE_READ  = 2'd2;
  localparam logic [1:0] DONE_FAIL  = 2'd3;

  // Bit positions in status_flags.
  localparam int FLAG_SB   = 0;
  localparam int FLAG_ADDR = 1;
  localparam int FLAG_TXE  = 2;
  localparam int FLAG_BTF  = 3;
  localparam int FLAG_RXNE = 4;

  // Direction bit appended to the device address.
  localparam logic DIR_WRITE = 1'b0;
  localparam logic DIR_READ  = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WR   = 2'd1,
    MODE_RD   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0] op;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] wr_value;
    logic [4:0] status_flags;
    logic [7:0] rx_data;
  } req_item_t;

  typedef struct packed {
    logic       accepted;
    logic       dr_write;
    logic [7:0] dr_data;
    logic       gen_start;
    logic       gen_stop;
    logic       ack_clear;
    logic       sr2_read;
    logic [1:0] done_code;
    logic [7:0] read_data;
  } rsp_item_t;

  typedef struct packed {
    mode_t      mode;
    logic [2:0] step;
    logic [6:0] held_dev_addr;
    logic [7:0] held_reg_addr;
    logic [7:0] held_value;
  } seq_state_t;

endpackage

// ===== rtl/i2cras_step.sv =====
module i2cras_step (
  input  i2cras_pkg::seq_state_t cur,
  input  i2cras_pkg::req_item_t  item,
  output i2cras_pkg::seq_state_t nxt,
  output i2cras_pkg::rsp_item_t  rsp
);
  import i2cras_pkg::*;

  // Step numbers of the write sequence.
  localparam logic [2:0] WR_SEND_ADDR  = 3'd0;
  localparam logic [2:0] WR_SEND_REG   = 3'd1;
  localparam logic [2:0] WR_SEND_VALUE = 3'd2;
  localparam logic [2:0] WR_FINISH     = 3'd3;
  // Step numbers of the read sequence.
  localparam logic [2:0] RD_SEND_ADDR  = 3'd0;
  localparam logic [2:0] RD_SEND_REG   = 3'd1;
  localparam logic [2:0] RD_RESTART    = 3'd2;
  localparam logic [2:0] RD_SEND_RADDR = 3'd3;
  localparam logic [2:0] RD_STOP       = 3'd4;
  localparam logic [2:0] RD_CAPTURE    = 3'd5;

  logic [7:0] addr_byte;
  logic [4:0] fl;

  assign addr_byte = {cur.held_dev_addr, DIR_WRITE};
  assign fl        = item.status_flags;

  always_comb begin
    nxt = cur;
    rsp = '0;
    case (item.op)
      OP_WRITE, OP_READ: begin
        if (cur.mode == MODE_IDLE) begin
          rsp.accepted      = 1'b1;
          rsp.gen_start     = 1'b1;
          nxt.mode          = (item.op == OP_WRITE) ? MODE_WR : MODE_RD;
          nxt.step          = WR_SEND_ADDR;
          nxt.held_dev_addr = item.dev_addr;
          nxt.held_reg_addr = item.reg_addr;
          if (item.op == OP_WRITE) begin
            nxt.held_value = item.wr_value;
          end
        end
      end
      OP_ERROR: begin
        rsp.gen_stop = 1'b1;
        rsp.sr2_read = 1'b1;
        if (cur.mode == MODE_WR || cur.mode == MODE_RD) begin
          rsp.done_code = DONE_FAIL;
        end
        nxt.mode = MODE_IDLE;
        nxt.step = WR_SEND_ADDR;
      end
      OP_STATUS: begin
        case (cur.mode)
          MODE_WR: begin
            case (cur.step)
              WR_SEND_ADDR: if (fl[FLAG_SB]) begin
                rsp.dr_write = 1'b1;
                rsp.dr_data  = addr_byte;
                nxt.step     = WR_SEND_REG;
              end
              WR_SEND_REG: if (fl[FLAG_ADDR]) begin
                rsp.sr2_read = 1'b1;
                rsp.dr_write = 1'b1;
                rsp.dr_data  = cur.held_reg_addr;
                nxt.step     = WR_SEND_VALUE;
              end
              WR_SEND_VALUE: if (fl[FLAG_TXE]) begin
                rsp.dr_write = 1'b1;
                rsp.dr_data  = cur.held_value;
                nxt.step     = WR_FINISH;
              end
              WR_FINISH: if (fl[FLAG_BTF]) begin
                rsp.gen_stop  = 1'b1;
                rsp.done_code = DONE_WRITE;
                nxt.step      = WR_SEND_ADDR;
                nxt.mode      = MODE_IDLE;
              end
              default: ;
            endcase
          end
          MODE_RD: begin
            case (cur.step)
              RD_SEND_ADDR: if (fl[FLAG_SB]) begin
                rsp.dr_write = 1'b1;
                rsp.dr_data  = addr_byte;
                nxt.step     = RD_SEND_REG;
              end
              RD_SEND_REG: if (fl[FLAG_ADDR]) begin
                rsp.sr2_read = 1'b1;
                rsp.dr_write = 1'b1;
                rsp.dr_data  = cur.held_reg_addr;
                nxt.step     = RD_RESTART;
              end
              RD_RESTART: if (fl[FLAG_BTF]) begin
                rsp.gen_start = 1'b1;
                nxt.step      = RD_SEND_RADDR;
              end
              RD_SEND_RADDR: if (fl[FLAG_SB]) begin
                rsp.dr_write  = 1'b1;
                rsp.dr_data   = {cur.held_dev_addr, DIR_READ};
                rsp.ack_clear = 1'b1;
                nxt.step      = RD_STOP;
              end
              RD_STOP: if (fl[FLAG_ADDR]) begin
                rsp.sr2_read = 1'b1;
                rsp.gen_stop = 1'b1;
                nxt.step     = RD_CAPTURE;
              end
              RD_CAPTURE: if (fl[FLAG_RXNE]) begin
                rsp.done_code = DONE_READ;
                rsp.read_data = item.rx_data;
                nxt.step      = RD_SEND_ADDR;
                nxt.mode      = MODE_IDLE;
              end
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/i2c_register_access_sequencer_core.sv =====
// Channel   Direction  Handshake                  Payload
// req       in         req_valid / req_stall      i2cras_pkg::req_item_t
// rsp       out        rsp_valid / rsp_stall      i2cras_pkg::rsp_item_t
//
// Every request item yields exactly one response item. While rsp_stall is low, one item
// per cycle is sustained; the sequencer state updates in the same cycle that
// an item leaves the input register, so consecutive items see each other's effects.
// Reset (rst, synchronous) empties both registers and returns the sequencer to idle.
// A stalled response holds the result register; the input register still drains into it
// only when it frees, and req_stall rises only when both registers are occupied.
module i2c_register_access_sequencer_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  i2cras_pkg::req_item_t req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output i2cras_pkg::rsp_item_t rsp
);
  import i2cras_pkg::*;

  // Input register: holds the accepted item until the result register can take its result.
  logic       held_valid;
  req_item_t  held;

  // Sequencer state: mode, step and the latched request fields.
  seq_state_t st;
  seq_state_t st_next;
  rsp_item_t  rsp_next;

  logic out_free;
  logic advance;
  logic take;

  // The result register can load when it is empty or its item leaves this cycle.
  assign out_free  = !rsp_valid || !rsp_stall;
  assign advance   = held_valid && out_free;
  // The input register can load when it is empty or drains this cycle.
  assign req_stall = held_valid && !out_free;
  assign take      = req_valid && !req_stall;

  // All of the per-event decision is one pass of small combinational logic.
  i2cras_step u_step (
    .cur  (st),
    .item (held),
    .nxt  (st_next),
    .rsp  (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid       <= 1'b0;
      rsp_valid        <= 1'b0;
      st.mode          <= MODE_IDLE;
      st.step          <= '0;
      st.held_dev_addr <= '0;
      st.held_reg_addr <= '0;
      st.held_value    <= '0;
    end else begin
      if (take) begin
        held_valid <= 1'b1;
      end else if (advance) begin
        held_valid <= 1'b0;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
        st        <= st_next;
      end else if (out_free) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      held <= req;
    end
    if (advance) begin
      rsp <= rsp_next;
    end
  end

  // Idle always sits at step zero.
  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    (st.mode == MODE_IDLE) |-> (st.step == 3'd0))
    else $error("idle mode with nonzero step");

  // A write sequence never goes past its fourth step.
  a_write_step_range: assert property (@(posedge clk) disable iff (rst)
    (st.mode == MODE_WR) |-> (st.step <= 3'd3))
    else $error("write sequence step out of range");

  // A request taken while idle starts a transfer.
  a_request_starts: assert property (@(posedge clk) disable iff (rst)
    (advance && st.mode == MODE_IDLE &&
     (held.op == OP_WRITE || held.op == OP_READ))
    |=> (st.mode != MODE_IDLE && rsp_valid && rsp.accepted && rsp.gen_start))
    else $error("idle request did not start a transfer");

  // An accepted request reports no completion.
  a_accept_no_done: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.accepted) |-> (rsp.done_code == DONE_NONE && !rsp.dr_write))
    else $error("accepted request carries completion or data");

  // The read byte is shown only with a read completion.
  a_read_data_gated: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.done_code != DONE_READ) |-> (rsp.read_data == 8'd0))
    else $error("read data without read completion");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import i2cras_pkg::*;

  // Sequence steps of a register write. Each step waits for one status flag.
  localparam logic [2:0] WSTEP_START   = 3'd0;  // waits for SB, sends the address byte
  localparam logic [2:0] WSTEP_ADDR    = 3'd1;  // waits for ADDR, sends the register number
  localparam logic [2:0] WSTEP_DATA    = 3'd2;  // waits for TXE, sends the value
  localparam logic [2:0] WSTEP_FINISH  = 3'd3;  // waits for BTF, raises STOP

  // Sequence steps of a register read.
  localparam logic [2:0] RSTEP_START   = 3'd0;  // waits for SB, sends the address byte
  localparam logic [2:0] RSTEP_ADDR    = 3'd1;  // waits for ADDR, sends the register number
  localparam logic [2:0] RSTEP_RESTART = 3'd2;  // waits for BTF, raises a repeated START
  localparam logic [2:0] RSTEP_RD_ADDR = 3'd3;  // waits for SB, sends address with read bit
  localparam logic [2:0] RSTEP_NACK    = 3'd4;  // waits for ADDR, raises STOP
  localparam logic [2:0] RSTEP_CAPTURE = 3'd5;  // waits for RXNE, captures the byte

  // A run with no item accepted on either channel for this many cycles is hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // The receiver holds off once for this many cycles so that both registers fill.
  localparam int BACKPRESSURE_CYCLES = 80;

  // One entry of the stimulus queue. When drain is set, the sender waits until
  // every expected result has come back before it offers this item.
  typedef struct packed {
    logic      drain;
    req_item_t item;
  } queued_req_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rsp_item_t rsp;

  i2c_register_access_sequencer_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  queued_req_t pending_reqs[$];
  rsp_item_t   expected_rsps[$];
  bit          drain_next = 1'b0;

  int reqs_taken = 0;
  int rsps_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  bit timed_out = 1'b0;

  // Both sides run without any idling over a stretch in the middle of the run.
  wire calm_stretch = (reqs_taken >= 500) && (reqs_taken < 650);

  // Shadow copy of the sequencer state, advanced once per accepted request item.
  mode_t      seq_mode;
  logic [2:0] seq_step;
  logic [6:0] seq_dev;
  logic [7:0] seq_reg;
  logic [7:0] seq_val;

  // Works out the response item for one request item and advances the shadow
  // state. Requests are taken only from idle; status events move one step
  // at most and only when the flag awaited by that step is set; an error
  // event always raises STOP and reads SR2, and fails a transfer in flight.
  function automatic rsp_item_t advance_sequencer(input req_item_t r);
    rsp_item_t  o;
    logic [7:0] addr_byte;
    o = '0;
    addr_byte = {seq_dev, DIR_WRITE};
    case (r.op)
      OP_WRITE, OP_READ: begin
        if (seq_mode == MODE_IDLE) begin
          o.accepted  = 1'b1;
          o.gen_start = 1'b1;
          if (r.op == OP_WRITE) begin
            seq_mode = MODE_WR;
            seq_val  = r.wr_value;
          end else begin
            seq_mode = MODE_RD;
          end
          seq_step = WSTEP_START;
          seq_dev  = r.dev_addr;
          seq_reg  = r.reg_addr;
        end
      end
      OP_ERROR: begin
        o.gen_stop = 1'b1;
        o.sr2_read = 1'b1;
        if (seq_mode != MODE_IDLE) o.done_code = DONE_FAIL;
        seq_mode = MODE_IDLE;
        seq_step = WSTEP_START;
      end
      default: begin
        if (seq_mode == MODE_WR) begin
          case (seq_step)
            WSTEP_START: if (r.status_flags[FLAG_SB]) begin
              o.dr_write = 1'b1;
              o.dr_data  = addr_byte;
              seq_step   = WSTEP_ADDR;
            end
            WSTEP_ADDR: if (r.status_flags[FLAG_ADDR]) begin
              o.sr2_read = 1'b1;
              o.dr_write = 1'b1;
              o.dr_data  = seq_reg;
              seq_step   = WSTEP_DATA;
            end
            WSTEP_DATA: if (r.status_flags[FLAG_TXE]) begin
              o.dr_write = 1'b1;
              o.dr_data  = seq_val;
              seq_step   = WSTEP_FINISH;
            end
            WSTEP_FINISH: if (r.status_flags[FLAG_BTF]) begin
              o.gen_stop  = 1'b1;
              o.done_code = DONE_WRITE;
              seq_step    = WSTEP_START;
              seq_mode    = MODE_IDLE;
            end
            default: ;
          endcase
        end else if (seq_mode == MODE_RD) begin
          case (seq_step)
            RSTEP_START: if (r.status_flags[FLAG_SB]) begin
              o.dr_write = 1'b1;
              o.dr_data  = addr_byte;
              seq_step   = RSTEP_ADDR;
            end
            RSTEP_ADDR: if (r.status_flags[FLAG_ADDR]) begin
              o.sr2_read = 1'b1;
              o.dr_write = 1'b1;
              o.dr_data  = seq_reg;
              seq_step   = RSTEP_RESTART;
            end
            RSTEP_RESTART: if (r.status_flags[FLAG_BTF]) begin
              o.gen_start = 1'b1;
              seq_step    = RSTEP_RD_ADDR;
            end
            RSTEP_RD_ADDR: if (r.status_flags[FLAG_SB]) begin
              o.dr_write  = 1'b1;
              o.dr_data   = {seq_dev, DIR_READ};
              o.ack_clear = 1'b1;
              seq_step    = RSTEP_NACK;
            end
            RSTEP_NACK: if (r.status_flags[FLAG_ADDR]) begin
              o.sr2_read = 1'b1;
              o.gen_stop = 1'b1;
              seq_step   = RSTEP_CAPTURE;
            end
            RSTEP_CAPTURE: if (r.status_flags[FLAG_RXNE]) begin
              o.done_code = DONE_READ;
              o.read_data = r.rx_data;
              seq_step    = RSTEP_START;
              seq_mode    = MODE_IDLE;
            end
            default: ;
          endcase
        end
      end
    endcase
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_item(input logic [1:0] op, input logic [6:0] dev,
                           input logic [7:0] reg_num, input logic [7:0] value,
                           input logic [4:0] flags, input logic [7:0] rx);
    queued_req_t e;
    e.drain = drain_next;
    e.item  = '{op: op, dev_addr: dev, reg_addr: reg_num, wr_value: value,
                status_flags: flags, rx_data: rx};
    pending_reqs.push_back(e);
    drain_next = 1'b0;
  endtask

  // An item of the given code with every other field random.
  task automatic push_random(input logic [1:0] op, input logic [4:0] flags);
    push_item(op, 7'($urandom), 8'($urandom), 8'($urandom), flags, 8'($urandom));
  endtask

  // Status flags with the awaited bit forced on, or forced off.
  function automatic logic [4:0] flags_with(input int bit_pos);
    return 5'($urandom_range(0, 31)) | (5'd1 << bit_pos);
  endfunction

  function automatic logic [4:0] flags_without(input int bit_pos);
    return 5'($urandom_range(0, 31)) & ~(5'd1 << bit_pos);
  endfunction

  // One well-formed transfer with random content. Before each step a few
  // events may arrive that lack the awaited flag, or requests that the busy
  // sequencer must turn away. Now and then the transfer is cut short by an
  // error event.
  task automatic queue_transfer(input bit is_read);
    int awaited[$];
    int abort_at;
    if (is_read) awaited = '{FLAG_SB, FLAG_ADDR, FLAG_BTF, FLAG_SB, FLAG_ADDR, FLAG_RXNE};
    else         awaited = '{FLAG_SB, FLAG_ADDR, FLAG_TXE, FLAG_BTF};
    abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, awaited.size() - 1) : -1;
    push_random(is_read ? OP_READ : OP_WRITE, 5'($urandom));
    foreach (awaited[i]) begin
      if (i == abort_at) begin
        push_random(OP_ERROR, 5'($urandom));
        return;
      end
      while ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 2) == 0) push_random(2'($urandom_range(0, 1)), 5'($urandom));
        else                           push_random(OP_STATUS, flags_without(awaited[i]));
      end
      push_random(OP_STATUS, flags_with(awaited[i]));
    end
  endtask

  // Sender. An item stays on the bus until it is taken. Once the slot is free
  // the next queued item is offered unless a random gap falls here, or the
  // item asks to wait for all outstanding results. The shadow state advances
  // at the clock edge where the item is taken.
  always @(posedge clk) begin : send_requests
    queued_req_t head;
    if (rst) begin
      req_valid <= 1'b0;
      seq_mode = MODE_IDLE;
      seq_step = WSTEP_START;
      seq_dev  = '0;
      seq_reg  = '0;
      seq_val  = '0;
    end else begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(advance_sequencer(req));
        reqs_taken <= reqs_taken + 1;
      end
      if (!req_valid || !req_stall) begin
        if (pending_reqs.size() != 0
            && (calm_stretch || $urandom_range(0, 99) >= 29)
            && !(pending_reqs[0].drain && expected_rsps.size() != 0)) begin
          head = pending_reqs.pop_front();
          req       <= head.item;
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver. Every taken response item is compared field by field with the
  // oldest expectation. The stall is random, except over the calm stretch,
  // and once the receiver holds off for a long time so that the block backs
  // up into its input.
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk) begin : receive_responses
    rsp_item_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsps_seen++;
        if (expected_rsps.size() == 0) begin
          $error("response item with no request item waiting for it");
          mismatches++;
        end else begin
          want = expected_rsps.pop_front();
          check_field("accepted",  8'(want.accepted),  8'(rsp.accepted));
          check_field("dr_write",  8'(want.dr_write),  8'(rsp.dr_write));
          check_field("dr_data",   want.dr_data,       rsp.dr_data);
          check_field("gen_start", 8'(want.gen_start), 8'(rsp.gen_start));
          check_field("gen_stop",  8'(want.gen_stop),  8'(rsp.gen_stop));
          check_field("ack_clear", 8'(want.ack_clear), 8'(rsp.ack_clear));
          check_field("sr2_read",  8'(want.sr2_read),  8'(rsp.sr2_read));
          check_field("done_code", 8'(want.done_code), 8'(rsp.done_code));
          check_field("read_data", want.read_data,     rsp.read_data);
        end
      end
      if (!hold_done && rsps_seen >= 200) begin
        hold_done = 1'b1;
        hold_left = BACKPRESSURE_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (calm_stretch) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < 29);
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
    end
  end

  initial begin
    bit mid_drain_set;
    int pick;
    int burst;
    mid_drain_set = 1'b0;

    // Directed part. A status event and an error event while idle, then a
    // write with all-ones fields that a busy request must not disturb and whose
    // steps see both a missing awaited flag and extra flags. A read with
    // all-zero fields, a busy read request in its middle and a capture of
    // 0xFF, then a read cut short by an error event, and an all-zero write.
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h1F, 8'h00);
    push_item(OP_ERROR,  7'h7F, 8'hFF, 8'hFF, 5'h1F, 8'hFF);
    push_item(OP_WRITE,  7'h7F, 8'hFF, 8'hFF, 5'h00, 8'h00);
    push_item(OP_WRITE,  7'h00, 8'h00, 8'h00, 5'h00, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h1E, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h01, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h1F, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h04, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h08, 8'h00);
    push_item(OP_READ,   7'h00, 8'h00, 8'hFF, 5'h1F, 8'hFF);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h01, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h02, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h08, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h1E, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h01, 8'h00);
    push_item(OP_READ,   7'h7F, 8'hFF, 8'hFF, 5'h00, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h02, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h10, 8'hFF);
    push_item(OP_READ,   7'h7F, 8'hFF, 8'h00, 5'h00, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h01, 8'h00);
    push_item(OP_ERROR,  7'h00, 8'h00, 8'h00, 5'h00, 8'h00);
    push_item(OP_WRITE,  7'h00, 8'h00, 8'h00, 5'h00, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h01, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h02, 8'h00);
    push_item(OP_STATUS, 7'h00, 8'h00, 8'h00, 5'h1F, 8'h00);

    // Random part. The sender pauses until the block has drained at its start
    // and once again halfway through.
    drain_next = 1'b1;
    while (pending_reqs.size() < 925) begin
      if (!mid_drain_set && pending_reqs.size() >= 450) begin
        mid_drain_set = 1'b1;
        drain_next    = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_transfer(1'b0);
      end else if (pick < 90) begin
        queue_transfer(1'b1);
      end else begin
        // Noise of any kind, then an error event to get back to idle.
        burst = $urandom_range(1, 4);
        repeat (burst) push_random(2'($urandom), 5'($urandom));
        push_random(OP_ERROR, 5'($urandom));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while ((pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
           && !timed_out)
      @(posedge clk);
    // Then wait on for any stray response items before the final check.
    if (!timed_out) repeat (10) @(posedge clk);

    if (expected_rsps.size() != 0) begin
      $error("%0d expected response items never arrived", expected_rsps.size());
      mismatches++;
    end
    if (mismatches == 0 && !timed_out) $display("tb: PASS");
    else                                $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/i2cras_pkg.sv
rtl/i2cras_step.sv
rtl/i2c_register_access_sequencer_core.sv
tb/tb.sv
